/* hdl/esc_pkg.sv */
package esc_pkg;

    // Bus and storage sizes
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int FIFO_DEPTH  = 4;
    localparam int DIV_BITS    = 64;

    // Compensation constants
    localparam logic [31:0] C_P_OFFSET = 32'd128000;
    localparam logic [31:0] C_P_BASE   = 32'd1048576;
    localparam logic [31:0] C_P_SCALE  = 32'd3125;
    localparam logic [31:0] C_H_OFFSET = 32'd76800;
    localparam logic [31:0] HUM_CLAMP  = 32'd419430400;
    localparam logic [31:0] C_H_ROUND  = 32'd16384;
    localparam logic [31:0] C_H_BIAS   = 32'd2097152;
    localparam logic [31:0] C_H_MID    = 32'd32768;
    localparam logic [31:0] C_H_RND2   = 32'd8192;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP    = 3'd0,
        CFG_PRESS_A = 3'd1,
        CFG_PRESS_B = 3'd2,
        CFG_MIXED   = 3'd3,
        CFG_HUM     = 3'd4
    } cfg_idx_e;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [11:0] h4;
        logic [11:0] h5;
        logic [7:0]  h6;
    } cal_t;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } in_t;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
        logic               pressure_valid;
    } out_t;

    // Front pipeline stages
    typedef struct packed {
        logic [19:0]        raw_p;
        logic [15:0]        raw_h;
        logic signed [33:0] prod1;
        logic signed [33:0] sq2;
    } ft1_t;

    typedef struct packed {
        logic [19:0]        raw_p;
        logic [15:0]        raw_h;
        logic signed [22:0] v1t;
        logic signed [37:0] m2;
    } ft2_t;

    // Queue entry from front to back
    typedef struct packed {
        logic [19:0] raw_p;
        logic [15:0] raw_h;
        logic [31:0] tf;
        logic [31:0] temp;
    } fb_t;

    // Back pipeline working set
    typedef struct packed {
        logic [19:0] raw_p;
        logic [15:0] raw_h;
        logic [31:0] temp;
        logic [63:0] sq;
        logic [63:0] v1p5;
        logic [63:0] v1p2;
        logic [31:0] h5v;
        logic [31:0] hvh6;
        logic [31:0] hvh3;
        logic [63:0] v2;
        logic [63:0] v1a;
        logic [31:0] ha;
        logic [31:0] hb1;
        logic [31:0] hb2;
        logic [63:0] v1b;
        logic [63:0] num;
        logic [31:0] hb;
        logic [31:0] hc;
        logic [63:0] num_abs;
        logic [63:0] den_abs;
        logic        neg;
        logic        zero;
        logic [31:0] hv2;
        logic [31:0] sqh;
        logic [16:0] hum;
    } bk_t;

    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        zero;
    } dv_side_t;

    typedef struct packed {
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
        logic                neg;
        dv_side_t            side;
    } dv_in_t;

    typedef struct packed {
        logic [DIV_BITS-1:0] quo;
        logic                neg;
        dv_side_t            side;
    } dv_out_t;

    typedef struct packed {
        logic [DIV_BITS-1:0] rem;
        logic [DIV_BITS-1:0] nq;
        logic [DIV_BITS-1:0] den;
        logic                neg;
        dv_side_t            side;
    } dv_stage_t;

    // Post-division working set
    typedef struct packed {
        logic [63:0] q;
        logic [63:0] qp8;
        logic [63:0] pp0;
        logic [31:0] pp1;
        logic [63:0] ss;
        logic [63:0] m9;
        logic [31:0] temp;
        logic [16:0] hum;
        logic        zero;
    } pk_t;

endpackage

/* hdl/esc_front.sv */
module esc_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  esc_pkg::in_t  s_data,
    input  esc_pkg::cal_t cal,
    output logic          fb_valid,
    input  logic          fb_ready,
    output esc_pkg::fb_t  fb_data
);

    esc_pkg::ft1_t f1_reg, f1_next;
    esc_pkg::ft2_t f2_reg, f2_next;
    esc_pkg::fb_t  f3_reg, f3_next;
    logic          f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic          en;

    logic signed [17:0] d1;
    logic signed [16:0] d2;
    logic signed [31:0] tf;
    logic signed [31:0] t5;

    // Advance unless the last stage is blocked by the queue
    assign en      = !f3_valid_reg || fb_ready;
    assign s_ready = en;

    // Stage 1: raw differences and first products
    always_comb begin
        d1 = $signed({1'b0, s_data.raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
        d2 = $signed({1'b0, s_data.raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
        f1_next.raw_p = s_data.raw_pressure;
        f1_next.raw_h = s_data.raw_humidity;
        f1_next.prod1 = d1 * $signed(cal.t2);
        f1_next.sq2   = d2 * d2;
    end

    // Stage 2: scale and apply the curvature coefficient
    always_comb begin
        f2_next.raw_p = f1_reg.raw_p;
        f2_next.raw_h = f1_reg.raw_h;
        f2_next.v1t   = 23'(f1_reg.prod1 >>> 11);
        f2_next.m2    = $signed(f1_reg.sq2[33:12]) * $signed(cal.t3);
    end

    // Stage 3: fine temperature and centidegrees
    always_comb begin
        tf = 32'(f2_reg.v1t) + 32'(f2_reg.m2 >>> 14);
        t5 = tf + (tf <<< 2) + 32'sd128;
        f3_next.raw_p = f2_reg.raw_p;
        f3_next.raw_h = f2_reg.raw_h;
        f3_next.tf    = tf;
        f3_next.temp  = t5 >>> 8;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= s_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
        end
    end

    assign fb_valid = f3_valid_reg;
    assign fb_data  = f3_reg;

endmodule

/* hdl/esc_fifo.sv */
module esc_fifo #(
    parameter int DEPTH = esc_pkg::FIFO_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  esc_pkg::fb_t wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output esc_pkg::fb_t rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    esc_pkg::fb_t     mem_reg [DEPTH];
    esc_pkg::fb_t     head_reg;
    logic             head_valid_reg, head_valid_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop, load;

    assign wr_ready = cnt_reg != CNT_W'(DEPTH);
    assign rd_valid = head_valid_reg;
    assign rd_data  = head_reg;
    assign push     = wr_valid && wr_ready;
    assign pop      = head_valid_reg && rd_ready;
    // Refill the head register whenever it is empty or being taken
    assign load     = (cnt_reg != '0) && (!head_valid_reg || rd_ready);

    // Advance pointers with wrap, track fill
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (load) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next        = cnt_reg + CNT_W'(push) - CNT_W'(load);
        head_valid_next = load || (head_valid_reg && !pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            head_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            cnt_reg        <= cnt_next;
            head_valid_reg <= head_valid_next;
        end
    end

    // Store on push, read the oldest entry into the head register
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
        if (load) begin
            head_reg <= mem_reg[rd_ptr_reg];
        end
    end

endmodule

/* hdl/esc_div.sv */
module esc_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  esc_pkg::dv_in_t  in_data,
    output logic             out_valid,
    output esc_pkg::dv_out_t out_data
);

    localparam int N = esc_pkg::DIV_BITS;

    esc_pkg::dv_stage_t st_reg [N];
    esc_pkg::dv_stage_t init;
    logic [N-1:0]       vld_reg;

    // One quotient bit: shift in a dividend bit, subtract if it fits
    function automatic esc_pkg::dv_stage_t div_step(input esc_pkg::dv_stage_t s);
        esc_pkg::dv_stage_t r;
        logic [N:0]         sh;
        logic [N:0]         df;
        r  = s;
        sh = {s.rem, s.nq[N-1]};
        df = sh - {1'b0, s.den};
        if (!df[N]) begin
            r.rem = df[N-1:0];
            r.nq  = {s.nq[N-2:0], 1'b1};
        end else begin
            r.rem = sh[N-1:0];
            r.nq  = {s.nq[N-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        init.rem  = '0;
        init.nq   = in_data.num;
        init.den  = in_data.den;
        init.neg  = in_data.neg;
        init.side = in_data.side;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= div_step(init);
            for (int k = 1; k < N; k++) begin
                st_reg[k] <= div_step(st_reg[k-1]);
            end
        end
    end

    assign out_valid     = vld_reg[N-1];
    assign out_data.quo  = st_reg[N-1].nq;
    assign out_data.neg  = st_reg[N-1].neg;
    assign out_data.side = st_reg[N-1].side;

endmodule

/* hdl/esc_back.sv */
module esc_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  esc_pkg::fb_t  q_data,
    input  esc_pkg::cal_t cal,
    output logic          m_valid,
    input  logic          m_ready,
    output esc_pkg::out_t m_data
);

    esc_pkg::bk_t b1_reg, b2_reg, b3_reg, b4_reg, b5_reg, b6_reg, b7_reg;
    esc_pkg::bk_t b1_next, b2_next, b3_next, b4_next, b5_next, b6_next, b7_next;
    logic [6:0]   bv_reg;
    esc_pkg::pk_t p1_reg, p2_reg, p3_reg, p4_reg;
    esc_pkg::pk_t p1_next, p2_next, p3_next, p4_next;
    logic [3:0]   pv_reg;
    esc_pkg::out_t out_reg, out_next;
    logic         out_valid_reg;
    logic         en;

    esc_pkg::dv_in_t  dv_in;
    esc_pkg::dv_out_t dv_out;
    logic             dv_valid;

    logic signed [31:0] v1_32;
    logic [31:0]        hv;
    logic [63:0]        prod_b2;
    logic [63:0]        den;
    logic [63:0]        pd;
    logic [31:0]        s15;
    logic [31:0]        hcorr;
    logic [31:0]        hf;
    logic [31:0]        hcl;
    logic [63:0]        s13;
    logic [63:0]        pr;

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] b);
        return {{48{b[15]}}, b};
    endfunction

    // Whole back end advances unless a result is held
    assign en      = !out_valid_reg || m_ready;
    assign q_ready = en;

    // B1: first-order products
    always_comb begin
        v1_32 = $signed(q_data.tf) - $signed(esc_pkg::C_P_OFFSET);
        hv    = q_data.tf - esc_pkg::C_H_OFFSET;
        b1_next       = '0;
        b1_next.raw_p = q_data.raw_p;
        b1_next.raw_h = q_data.raw_h;
        b1_next.temp  = q_data.temp;
        b1_next.sq    = v1_32 * v1_32;
        b1_next.v1p5  = v1_32 * $signed(cal.p5);
        b1_next.v1p2  = v1_32 * $signed(cal.p2);
        b1_next.h5v   = hv * {{20{cal.h5[11]}}, cal.h5};
        b1_next.hvh6  = hv * {{24{cal.h6[7]}}, cal.h6};
        b1_next.hvh3  = hv * {24'b0, cal.h3};
    end

    // B2: pressure partial sums, humidity first terms
    always_comb begin
        b2_next = b1_reg;
        prod_b2 = b1_reg.sq * sx16(cal.p3);
        b2_next.v2  = b1_reg.sq * sx16(cal.p6) + (b1_reg.v1p5 << 17) + (sx16(cal.p4) << 35);
        b2_next.v1a = asr64(prod_b2, 8) + (b1_reg.v1p2 << 12);
        b2_next.ha  = asr32({2'b0, b1_reg.raw_h, 14'b0} - ({{20{cal.h4[11]}}, cal.h4} << 20)
                            - b1_reg.h5v + esc_pkg::C_H_ROUND, 15);
        b2_next.hb1 = asr32(b1_reg.hvh6, 10);
        b2_next.hb2 = asr32(b1_reg.hvh3, 11) + esc_pkg::C_H_MID;
    end

    // B3: divisor product, dividend, humidity product
    always_comb begin
        b3_next = b2_reg;
        pd  = 64'(esc_pkg::C_P_BASE) - {44'b0, b2_reg.raw_p};
        b3_next.v1b = (64'h0000_8000_0000_0000 + b2_reg.v1a) * {48'b0, cal.p1};
        b3_next.num = ((pd << 31) - b2_reg.v2) * 64'(esc_pkg::C_P_SCALE);
        b3_next.hb  = b2_reg.hb1 * b2_reg.hb2;
    end

    // B4: sign and magnitude for the divider, humidity scale
    always_comb begin
        b4_next = b3_reg;
        den = asr64(b3_reg.v1b, 33);
        b4_next.zero    = den == '0;
        b4_next.neg     = b3_reg.num[63] ^ den[63];
        b4_next.num_abs = b3_reg.num[63] ? 64'd0 - b3_reg.num : b3_reg.num;
        b4_next.den_abs = den[63] ? 64'd0 - den : den;
        b4_next.hc = asr32((asr32(b3_reg.hb, 10) + esc_pkg::C_H_BIAS) * {{16{cal.h2[15]}}, cal.h2}
                           + esc_pkg::C_H_RND2, 14);
    end

    // B5: humidity main product
    always_comb begin
        b5_next = b4_reg;
        b5_next.hv2 = b4_reg.ha * b4_reg.hc;
    end

    // B6: humidity square term
    always_comb begin
        b6_next = b5_reg;
        s15 = asr32(b5_reg.hv2, 15);
        b6_next.sqh = s15 * s15;
    end

    // B7: humidity correction and clamp
    always_comb begin
        b7_next = b6_reg;
        hcorr = asr32(asr32(b6_reg.sqh, 7) * {24'b0, cal.h1}, 4);
        hf    = b6_reg.hv2 - hcorr;
        if (hf[31]) begin
            hcl = '0;
        end else if (hf > esc_pkg::HUM_CLAMP) begin
            hcl = esc_pkg::HUM_CLAMP;
        end else begin
            hcl = hf;
        end
        b7_next.hum = hcl[28:12];
    end

    always_comb begin
        dv_in.num       = b7_reg.num_abs;
        dv_in.den       = b7_reg.den_abs;
        dv_in.neg       = b7_reg.neg;
        dv_in.side.temp = b7_reg.temp;
        dv_in.side.hum  = b7_reg.hum;
        dv_in.side.zero = b7_reg.zero;
    end

    esc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (bv_reg[6]),
        .in_data   (dv_in),
        .out_valid (dv_valid),
        .out_data  (dv_out)
    );

    // P1: restore quotient sign
    always_comb begin
        p1_next      = '0;
        p1_next.q    = dv_out.neg ? 64'd0 - dv_out.quo : dv_out.quo;
        p1_next.temp = dv_out.side.temp;
        p1_next.hum  = dv_out.side.hum;
        p1_next.zero = dv_out.side.zero;
    end

    // P2: partial products of the square, P8 term
    always_comb begin
        p2_next = p1_reg;
        s13 = asr64(p1_reg.q, 13);
        p2_next.pp0 = s13[31:0] * s13[31:0];
        p2_next.pp1 = s13[31:0] * s13[63:32];
        p2_next.qp8 = p1_reg.q * sx16(cal.p8);
    end

    // P3: combine the square
    always_comb begin
        p3_next = p2_reg;
        p3_next.ss = p2_reg.pp0 + {p2_reg.pp1[30:0], 33'b0};
    end

    // P4: P9 term
    always_comb begin
        p4_next = p3_reg;
        p4_next.m9 = p3_reg.ss * sx16(cal.p9);
    end

    // Output stage: final pressure
    always_comb begin
        pr = asr64(p4_reg.q + asr64(p4_reg.m9, 25) + asr64(p4_reg.qp8, 19), 8)
             + (sx16(cal.p7) << 4);
        out_next.temp_centi      = $signed(p4_reg.temp);
        out_next.pressure_q24_8  = p4_reg.zero ? 32'd0 : pr[31:0];
        out_next.humidity_q22_10 = p4_reg.hum;
        out_next.pressure_valid  = !p4_reg.zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg        <= '0;
            pv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            bv_reg        <= {bv_reg[5:0], q_valid};
            pv_reg        <= {pv_reg[2:0], dv_valid};
            out_valid_reg <= pv_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_reg  <= b1_next;
            b2_reg  <= b2_next;
            b3_reg  <= b3_next;
            b4_reg  <= b4_next;
            b5_reg  <= b5_next;
            b6_reg  <= b6_next;
            b7_reg  <= b7_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            p4_reg  <= p4_next;
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* hdl/env_sensor_compensation.sv */
// Throughput: one sample set per cycle unless the receiver holds results back;
// the 64-stage divider retires one quotient bit per stage, so a new dividend
// enters it on every cycle that the back end advances. While a result waits
// at the output, the front keeps accepting into the queue until it is full.
// Reset (aresetn low, synchronous): calibration registers clear to 0, all
// pipeline stages and the queue empty.
module env_sensor_compensation #(
    parameter int FIFO_DEPTH = esc_pkg::FIFO_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  esc_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output esc_pkg::out_t                  m_data,
    input  logic                           cfg_we,
    input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic [47:0]   cal_temp_reg;
    logic [63:0]   cal_press_a_reg;
    logic [63:0]   cal_press_b_reg;
    logic [47:0]   cal_mixed_reg;
    logic [31:0]   cal_hum_reg;
    esc_pkg::cal_t cal;

    logic          fb_valid, fb_ready;
    esc_pkg::fb_t  fb_data;
    logic          q_valid, q_ready;
    esc_pkg::fb_t  q_data;

    // Write calibration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_temp_reg    <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_mixed_reg   <= '0;
            cal_hum_reg     <= '0;
        end else if (cfg_we) begin
            case (esc_pkg::cfg_idx_e'(cfg_index))
                esc_pkg::CFG_TEMP:    cal_temp_reg    <= cfg_wdata[47:0];
                esc_pkg::CFG_PRESS_A: cal_press_a_reg <= cfg_wdata;
                esc_pkg::CFG_PRESS_B: cal_press_b_reg <= cfg_wdata;
                esc_pkg::CFG_MIXED:   cal_mixed_reg   <= cfg_wdata[47:0];
                esc_pkg::CFG_HUM:     cal_hum_reg     <= cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    // Unpack coefficients
    assign cal.t1 = cal_temp_reg[15:0];
    assign cal.t2 = cal_temp_reg[31:16];
    assign cal.t3 = cal_temp_reg[47:32];
    assign cal.p1 = cal_press_a_reg[15:0];
    assign cal.p2 = cal_press_a_reg[31:16];
    assign cal.p3 = cal_press_a_reg[47:32];
    assign cal.p4 = cal_press_a_reg[63:48];
    assign cal.p5 = cal_press_b_reg[15:0];
    assign cal.p6 = cal_press_b_reg[31:16];
    assign cal.p7 = cal_press_b_reg[47:32];
    assign cal.p8 = cal_press_b_reg[63:48];
    assign cal.p9 = cal_mixed_reg[15:0];
    assign cal.h1 = cal_mixed_reg[23:16];
    assign cal.h2 = cal_mixed_reg[39:24];
    assign cal.h3 = cal_mixed_reg[47:40];
    assign cal.h4 = cal_hum_reg[11:0];
    assign cal.h5 = cal_hum_reg[23:12];
    assign cal.h6 = cal_hum_reg[31:24];

    esc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cal      (cal),
        .fb_valid (fb_valid),
        .fb_ready (fb_ready),
        .fb_data  (fb_data)
    );

    esc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fb_valid),
        .wr_ready (fb_ready),
        .wr_data  (fb_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    esc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .cal     (cal),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Invalid pressure always reads as zero
    a_press_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.pressure_valid |-> m_data.pressure_q24_8 == 32'd0)
        else $error("invalid pressure not zero");

    // Humidity stays within the clamp range
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.humidity_q22_10 <= 17'd102400)
        else $error("humidity out of range");

    // Input stalls only when the queue blocks the front
    a_front_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> fb_valid && !fb_ready)
        else $error("front stalled without queue backpressure");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    esc_pkg::in_t                   s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    esc_pkg::out_t                  m_data;
    logic                           cfg_we = 1'b0;
    logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [esc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Calibration copies held by the predictor
    logic [63:0] cal_temp = '0;
    logic [63:0] cal_press_a = '0;
    logic [63:0] cal_press_b = '0;
    logic [63:0] cal_mixed = '0;
    logic [63:0] cal_hum = '0;

    esc_pkg::in_t  sample_q[$];
    esc_pkg::out_t reading_q[$];
    int   mismatches = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_mode = 0;
    int   stall_left = 0;

    env_sensor_compensation dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] sra64(logic [63:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] sra32(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    // Predict the compensated reading for one sample set
    function automatic esc_pkg::out_t compensate(esc_pkg::in_t x);
        logic [63:0] adt, adp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] d, v1, v2, tf, temp, p, num, ua, ub, q;
        logic [31:0] adh, h1, h2, h3, h4, h5, h6, v, a, b;
        esc_pkg::out_t r;
        adt = 64'(x.raw_temperature);
        adp = 64'(x.raw_pressure);
        adh = 32'(x.raw_humidity);
        t1 = 64'(cal_temp[15:0]);
        t2 = 64'($signed(cal_temp[31:16]));
        t3 = 64'($signed(cal_temp[47:32]));
        p1 = 64'(cal_press_a[15:0]);
        p2 = 64'($signed(cal_press_a[31:16]));
        p3 = 64'($signed(cal_press_a[47:32]));
        p4 = 64'($signed(cal_press_a[63:48]));
        p5 = 64'($signed(cal_press_b[15:0]));
        p6 = 64'($signed(cal_press_b[31:16]));
        p7 = 64'($signed(cal_press_b[47:32]));
        p8 = 64'($signed(cal_press_b[63:48]));
        p9 = 64'($signed(cal_mixed[15:0]));
        h1 = 32'(cal_mixed[23:16]);
        h2 = 32'($signed(cal_mixed[39:24]));
        h3 = 32'(cal_mixed[47:40]);
        h4 = 32'($signed(cal_hum[11:0]));
        h5 = 32'($signed(cal_hum[23:12]));
        h6 = 32'($signed(cal_hum[31:24]));

        // Temperature and fine value
        d = (adt >> 3) - (t1 << 1);
        v1 = sra64(d * t2, 11);
        d = (adt >> 4) - t1;
        v2 = sra64(sra64(d * d, 12) * t3, 14);
        tf = v1 + v2;
        temp = sra64(tf * 64'd5 + 64'd128, 8);

        // Pressure, 64-bit wrapping
        v1 = tf - 64'(esc_pkg::C_P_OFFSET);
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 64'd0) begin
            r.pressure_q24_8 = '0;
            r.pressure_valid = 1'b0;
        end else begin
            p = 64'(esc_pkg::C_P_BASE) - adp;
            num = ((p << 31) - v2) * 64'(esc_pkg::C_P_SCALE);
            ua = num[63] ? 64'd0 - num : num;
            ub = v1[63] ? 64'd0 - v1 : v1;
            q = ua / ub;
            p = (num[63] != v1[63]) ? 64'd0 - q : q;
            v1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
            v2 = sra64(p8 * p, 19);
            p = sra64(p + v1 + v2, 8) + (p7 << 4);
            r.pressure_q24_8 = p[31:0];
            r.pressure_valid = 1'b1;
        end

        // Humidity, 32-bit wrapping
        v = tf[31:0] - esc_pkg::C_H_OFFSET;
        a = sra32((adh << 14) - (h4 << 20) - h5 * v + esc_pkg::C_H_ROUND, 15);
        b = sra32(v * h6, 10) * (sra32(v * h3, 11) + esc_pkg::C_H_MID);
        b = sra32(b, 10) + esc_pkg::C_H_BIAS;
        b = sra32(b * h2 + esc_pkg::C_H_RND2, 14);
        v = a * b;
        v = v - sra32(sra32(sra32(v, 15) * sra32(v, 15), 7) * h1, 4);
        if (v[31]) begin
            v = '0;
        end else if (v > esc_pkg::HUM_CLAMP) begin
            v = esc_pkg::HUM_CLAMP;
        end
        r.temp_centi = temp[31:0];
        r.humidity_q22_10 = v[28:12];
        return r;
    endfunction

    // Driver: bursts with random gaps, fed from the sample queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                reading_q.push_back(compensate(s_data));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= sample_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: free, light or heavy back-pressure in stretches
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 1) == 0);
            end
            default: begin
                m_ready <= ($urandom_range(0, 4) == 0);
            end
        endcase
    end

    task automatic report(string field, logic [63:0] e, logic [63:0] a);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %s: expected %0h actual %0h", field, e, a);
        end
    endtask

    // Monitor: check each transaction against the oldest prediction
    always @(posedge aclk) begin
        esc_pkg::out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (reading_q.size() == 0) begin
                report("unexpected result", 64'd0, 64'(m_data));
            end else begin
                exp_r = reading_q.pop_front();
                if (m_data.temp_centi !== exp_r.temp_centi)
                    report("temp_centi", 64'(exp_r.temp_centi), 64'(m_data.temp_centi));
                if (m_data.pressure_q24_8 !== exp_r.pressure_q24_8)
                    report("pressure_q24_8", 64'(exp_r.pressure_q24_8),
                           64'(m_data.pressure_q24_8));
                if (m_data.humidity_q22_10 !== exp_r.humidity_q22_10)
                    report("humidity_q22_10", 64'(exp_r.humidity_q22_10),
                           64'(m_data.humidity_q22_10));
                if (m_data.pressure_valid !== exp_r.pressure_valid)
                    report("pressure_valid", 64'(exp_r.pressure_valid),
                           64'(m_data.pressure_valid));
            end
        end
    end

    task automatic write_cal(esc_pkg::cfg_idx_e idx, logic [63:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            esc_pkg::CFG_TEMP:    cal_temp = val & 64'hFFFF_FFFF_FFFF;
            esc_pkg::CFG_PRESS_A: cal_press_a = val;
            esc_pkg::CFG_PRESS_B: cal_press_b = val;
            esc_pkg::CFG_MIXED:   cal_mixed = val & 64'hFFFF_FFFF_FFFF;
            esc_pkg::CFG_HUM:     cal_hum = val & 64'hFFFF_FFFF;
            default: begin
            end
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_cal(logic [63:0] t, logic [63:0] pa, logic [63:0] pb,
                            logic [63:0] mx, logic [63:0] hm);
        write_cal(esc_pkg::CFG_TEMP, t);
        write_cal(esc_pkg::CFG_PRESS_A, pa);
        write_cal(esc_pkg::CFG_PRESS_B, pb);
        write_cal(esc_pkg::CFG_MIXED, mx);
        write_cal(esc_pkg::CFG_HUM, hm);
    endtask

    // Wait until every transaction is in and checked, then drain the pipeline
    task automatic drain();
        while (sample_q.size() != 0 || s_valid || reading_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (200) @(posedge aclk);
    endtask

    task automatic push_corners();
        sample_q.push_back('{20'd0, 20'd0, 16'd0});
        sample_q.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        sample_q.push_back('{20'hFFFFF, 20'd0, 16'h0000});
        sample_q.push_back('{20'd0, 20'hFFFFF, 16'hFFFF});
        sample_q.push_back('{20'hAAAAA, 20'h55555, 16'hAAAA});
        sample_q.push_back('{20'h55555, 20'hAAAAA, 16'h5555});
        sample_q.push_back('{20'd519888, 20'd415148, 16'd30000});
        sample_q.push_back('{20'd400000, 20'd300000, 16'd65535});
    endtask

    task automatic push_random(int n);
        esc_pkg::in_t x;
        repeat (n) begin
            if ($urandom_range(0, 9) < 7) begin
                x.raw_temperature = 20'($urandom_range(380000, 620000));
                x.raw_pressure = 20'($urandom_range(200000, 520000));
                x.raw_humidity = 16'($urandom_range(15000, 45000));
            end else begin
                x.raw_temperature = 20'($urandom);
                x.raw_pressure = 20'($urandom);
                x.raw_humidity = 16'($urandom);
            end
            sample_q.push_back(x);
        end
    endtask

    initial begin
        logic [63:0] typ_t, typ_pa, typ_pb, typ_mx, typ_hm;
        typ_t = 64'({16'hFC18, 16'd26435, 16'd27504});
        typ_pa = {16'd2855, 16'd3024, 16'hD843, 16'd36477};
        typ_pb = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
        typ_mx = 64'({8'd0, 16'd362, 8'd75, 16'd6000});
        typ_hm = 64'({8'd30, 12'd0, 12'd324});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset calibration: zero divisor everywhere
        push_corners();
        drain();

        // Typical part calibration
        load_cal(typ_t, typ_pa, typ_pb, typ_mx, typ_hm);
        push_corners();
        push_random(150);
        drain();

        // All ones in every register
        load_cal('1, '1, '1, '1, '1);
        push_corners();
        push_random(40);
        drain();

        // Zero P1 on an otherwise typical part
        load_cal(typ_t, {typ_pa[63:16], 16'd0}, typ_pb, typ_mx, typ_hm);
        push_random(30);
        drain();

        // Fully random calibration sets
        repeat (4) begin
            load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
            push_random(60);
            drain();
        end

        // Typical part with randomized humidity and pressure tails
        load_cal(typ_t, typ_pa, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom});
        push_random(90);
        drain();

        if (mismatches == 0 && reading_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: errors");
        $finish;
    end

endmodule

/* env_sensor_compensation.f */
hdl/esc_pkg.sv
hdl/esc_front.sv
hdl/esc_fifo.sv
hdl/esc_div.sv
hdl/esc_back.sv
hdl/env_sensor_compensation.sv
test/tb.sv
